// ===== hdl/sts_pkg.sv =====
// Shared types, constants and helpers for the simplex tableau solver.
// Used by every module of the block but the RAM; depends on nothing.
`default_nettype none

package sts_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 32;
    localparam int VAL_W     = 48;
    localparam int FRAC_W    = 24;
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CNT_W     = $clog2(MAX_COLS + 1);
    localparam int LR_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int TAB_DEPTH = (MAX_ROWS + 1) * MAX_COLS;
    localparam int ADDR_W    = $clog2(TAB_DEPTH);
    localparam int DELTA_ROW = MAX_ROWS;

    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int PIV_W      = 12;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t V_MAX = val_t'({1'b0, {(VAL_W-1){1'b1}}});
    localparam val_t V_MIN = val_t'({1'b1, {(VAL_W-1){1'b0}}});
    localparam val_t Q_ONE = val_t'(64'd1 << FRAC_W);

    // Magnitude caps for positive and negative results.
    localparam logic [VAL_W-1:0] CAP_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] CAP_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [1:0] KIND_TAB   = 2'd0;
    localparam logic [1:0] KIND_BASIS = 2'd1;
    localparam logic [1:0] KIND_ART   = 2'd2;
    localparam logic [1:0] KIND_SOLVE = 2'd3;

    localparam logic [1:0] STAT_OPTIMAL    = 2'd0;
    localparam logic [1:0] STAT_INFEASIBLE = 2'd1;
    localparam logic [1:0] STAT_UNBOUNDED  = 2'd2;
    localparam logic [1:0] STAT_LIMIT      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PIVOTS = 4'd3;

    // Request to and response from an arithmetic unit.
    typedef struct packed {
        logic start;
        val_t a;
        val_t b;
    } op_req_t;

    typedef struct packed {
        logic done;
        val_t res;
    } op_rsp_t;

    function automatic logic [VAL_W-1:0] mag(input val_t v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [ADDR_W-1:0] tab_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/simplex_tableau_solver_unit.sv =====
// Simplex tableau solver, big-M primal simplex in signed Q23.24 fixed point.
// A solve waits in each pivot on the bit-serial divider and the shared
// multiplier, then makes a last scan before the result beats follow. One item
// is worked on at a time.
// Reset: synchronous, active low; clears control and flags and sets the configuration registers to their defaults.
`default_nettype none

module simplex_tableau_solver_unit
    import sts_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input beats.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata, lowest bit up: row[4:0], col[9:5], value[57:10], zero pad.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[1:0].
    input  wire logic [1:0]            s_tuser,
    // Result beats.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata, lowest bit up: status[1:0], basis_col[6:2], amount[54:7], pad.
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast,
    // Configuration writes.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // The sequencer walks the tableau memory one entry at a time: it issues a
    // read address, uses the registered data in the following state and
    // writes results back. Where a write meets a read of the same entry, the
    // read data goes unused, so no forwarding is needed.
    typedef enum logic [4:0] {
        ST_IDLE, ST_EN_RD, ST_EN_CHK, ST_EN_DONE, ST_INF_RD, ST_INF_CHK,
        ST_LV_RDA, ST_LV_CHKA, ST_LV_DIV, ST_LV_WAIT, ST_LV_DONE,
        ST_PR_RDP, ST_PR_GETP, ST_PR_RD, ST_PR_DIV, ST_PR_WAIT,
        ST_EL_RDF, ST_EL_GETF, ST_EL_RDX, ST_EL_RDQ, ST_EL_MUL, ST_EL_WAIT,
        ST_EM_RD, ST_EM_OUT
    } state_t;

    state_t            state_reg;
    logic [4:0]        num_rows_reg;
    logic [5:0]        num_cols_reg;
    logic [1:0]        mode_reg;
    logic [PIV_W-1:0]  max_piv_reg, pcount_reg;
    logic [ROW_W-1:0]  row_reg, lr_reg, nr;
    logic [CNT_W-1:0]  col_reg, nc;
    logic [COL_W-1:0]  ec_reg;
    val_t              best_reg, bestr_reg, a_reg, p_reg, f_reg, x_reg;
    logic              have_c_reg, have_r_reg;
    logic [1:0]        status_reg;
    logic [COL_W-1:0]  basis_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] art_reg;
    logic              m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    val_t              ram_wdata, rdata;
    op_req_t           div_req, mul_req;
    op_rsp_t           div_rsp, mul_rsp;

    logic [4:0]        in_row;
    logic [COL_W-1:0]  in_col;
    val_t              in_value;
    logic              s_acc, load_ok, col_last, row_last, out_free;
    logic [ROW_W-1:0]  load_row, em_row;
    logic [COL_W-1:0]  col_idx;
    val_t              d_eff, diff_sat;
    logic [VAL_W:0]    diff;

    // Next row to eliminate: skips the pivot row and the unused rows up to
    // the delta row.
    function automatic logic [ROW_W-1:0] elim_row(input logic [ROW_W-1:0] c,
                                                  input logic [ROW_W-1:0] lr,
                                                  input logic [ROW_W-1:0] n);
        logic [ROW_W-1:0] c2;
        c2 = (c == lr) ? c + 1'b1 : c;
        return (c2 >= n) ? ROW_W'(DELTA_ROW) : c2;
    endfunction

    assign in_row   = s_tdata[4:0];
    assign in_col   = s_tdata[9:5];
    assign in_value = val_t'(s_tdata[57:10]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Used sizes, clamped to what the tableau holds.
    assign nr = (num_rows_reg == '0) ? ROW_W'(1)
              : ((num_rows_reg > 5'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : ROW_W'(num_rows_reg));
    assign nc = (num_cols_reg < 6'd2) ? CNT_W'(2)
              : ((num_cols_reg > 6'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(num_cols_reg));

    always_comb begin
        load_ok  = 1'b1;
        load_row = ROW_W'(in_row);
        if ((in_row == 5'(DELTA_ROW)) || (ROW_W'(in_row) == nr)) begin
            load_row = ROW_W'(DELTA_ROW);
        end else if (in_row >= 5'(MAX_ROWS)) begin
            load_ok = 1'b0;
        end
        col_idx  = col_reg[COL_W-1:0];
        col_last = (col_reg == nc - 1'b1);
        row_last = (row_reg == nr - 1'b1);
        out_free = !m_tvalid_reg || m_tready;
        em_row   = (row_reg == nr) ? ROW_W'(DELTA_ROW) : row_reg;
        // The delta is negated for a minimising mode, saturating at the top.
        if (mode_reg[1]) begin
            d_eff = (rdata == V_MIN) ? V_MAX : -rdata;
        end else begin
            d_eff = rdata;
        end
        diff     = {x_reg[VAL_W-1], x_reg} - {mul_rsp.res[VAL_W-1], mul_rsp.res};
        diff_sat = (diff[VAL_W] != diff[VAL_W-1]) ? (diff[VAL_W] ? V_MIN : V_MAX)
                                                  : val_t'(diff[VAL_W-1:0]);
    end

    // Read address of the memory for each state.
    always_comb begin
        case (state_reg)
            ST_EN_RD:            ram_raddr = tab_addr(ROW_W'(DELTA_ROW), col_idx);
            ST_INF_RD:           ram_raddr = tab_addr(row_reg, '0);
            ST_LV_RDA:           ram_raddr = tab_addr(row_reg, ec_reg);
            ST_LV_CHKA:          ram_raddr = tab_addr(row_reg, '0);
            ST_PR_RDP:           ram_raddr = tab_addr(lr_reg, ec_reg);
            ST_PR_RD:            ram_raddr = tab_addr(lr_reg, col_idx);
            ST_EL_RDF:           ram_raddr = tab_addr(row_reg, ec_reg);
            ST_EL_RDX:           ram_raddr = tab_addr(row_reg, col_idx);
            ST_EL_RDQ:           ram_raddr = tab_addr(lr_reg, col_idx);
            ST_EM_RD, ST_EM_OUT: ram_raddr = tab_addr(em_row, '0);
            default:             ram_raddr = '0;
        endcase
    end

    // Write-back of loads, the new pivot row and the eliminated rows.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = tab_addr(row_reg, col_idx);
        ram_wdata = '0;
        case (state_reg)
            ST_IDLE: begin
                ram_we    = s_acc && (s_tuser == KIND_TAB) && load_ok;
                ram_waddr = tab_addr(load_row, in_col);
                ram_wdata = in_value;
            end
            ST_PR_RD: begin
                ram_we    = (col_idx == ec_reg);
                ram_waddr = tab_addr(lr_reg, col_idx);
                ram_wdata = Q_ONE;
            end
            ST_PR_WAIT: begin
                ram_we    = div_rsp.done;
                ram_waddr = tab_addr(lr_reg, col_idx);
                ram_wdata = div_rsp.res;
            end
            ST_EL_RDX: begin
                ram_we    = (col_idx == ec_reg);
            end
            ST_EL_WAIT: begin
                ram_we    = mul_rsp.done;
                ram_wdata = diff_sat;
            end
            default: ;
        endcase
    end

    always_comb begin
        div_req.start = (state_reg == ST_LV_DIV) || (state_reg == ST_PR_DIV);
        div_req.a     = rdata;
        div_req.b     = (state_reg == ST_PR_DIV) ? p_reg : a_reg;
        mul_req.start = (state_reg == ST_EL_MUL);
        mul_req.a     = rdata;
        mul_req.b     = f_reg;
    end

    sts_tab_ram #(
        .DEPTH  (TAB_DEPTH),
        .DATA_W (VAL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    sts_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));
    sts_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req), .rsp(mul_rsp));

    // Basis store: written by loads and at the end of each pivot.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_acc && s_tuser == KIND_BASIS
            && in_row < 5'(MAX_ROWS)) begin
            basis_mem[in_row[LR_W-1:0]] <= in_col;
        end else if (state_reg == ST_EL_WAIT && mul_rsp.done && col_last
                     && row_reg == ROW_W'(DELTA_ROW)) begin
            basis_mem[lr_reg[LR_W-1:0]] <= ec_reg;
        end else if (state_reg == ST_EL_RDX && col_idx == ec_reg && col_last
                     && row_reg == ROW_W'(DELTA_ROW)) begin
            basis_mem[lr_reg[LR_W-1:0]] <= ec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            num_rows_reg <= 5'd1;
            num_cols_reg <= 6'd32;
            mode_reg     <= 2'd1;
            max_piv_reg  <= PIV_W'(255);
            pcount_reg   <= '0;
            art_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_ROWS:   num_rows_reg <= cfg_data[4:0];
                    REG_NUM_COLS:   num_cols_reg <= cfg_data[5:0];
                    REG_MODE:       mode_reg     <= cfg_data[1:0];
                    REG_MAX_PIVOTS: max_piv_reg  <= cfg_data[PIV_W-1:0];
                    default: ;
                endcase
            end
            // The emitting state sets the valid flag itself.
            if (m_tready && state_reg != ST_EM_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (s_tuser)
                            KIND_ART: art_reg[in_col] <= in_value[0];
                            KIND_SOLVE: begin
                                pcount_reg <= '0;
                                col_reg    <= CNT_W'(1);
                                best_reg   <= '0;
                                have_c_reg <= 1'b0;
                                state_reg  <= ST_EN_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                // Entering column: first largest positive delta.
                ST_EN_RD: state_reg <= ST_EN_CHK;
                ST_EN_CHK: begin
                    if (d_eff > best_reg) begin
                        best_reg   <= d_eff;
                        ec_reg     <= col_idx;
                        have_c_reg <= 1'b1;
                    end
                    col_reg   <= col_reg + 1'b1;
                    state_reg <= col_last ? ST_EN_DONE : ST_EN_RD;
                end
                ST_EN_DONE: begin
                    row_reg    <= '0;
                    have_r_reg <= 1'b0;
                    state_reg  <= have_c_reg ? ST_LV_RDA : ST_INF_RD;
                end
                // Feasibility: any basic artificial column with positive rhs.
                ST_INF_RD: state_reg <= ST_INF_CHK;
                ST_INF_CHK: begin
                    if (art_reg[basis_mem[row_reg[LR_W-1:0]]] && rdata > 0) begin
                        status_reg <= STAT_INFEASIBLE;
                        row_reg    <= '0;
                        state_reg  <= ST_EM_RD;
                    end else if (row_last) begin
                        status_reg <= STAT_OPTIMAL;
                        row_reg    <= '0;
                        state_reg  <= ST_EM_RD;
                    end else begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_INF_RD;
                    end
                end
                // Leaving row: smallest ratio over positive entries.
                ST_LV_RDA: state_reg <= ST_LV_CHKA;
                ST_LV_CHKA: begin
                    if (rdata > 0) begin
                        a_reg     <= rdata;
                        state_reg <= ST_LV_DIV;
                    end else if (row_last) begin
                        state_reg <= ST_LV_DONE;
                    end else begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_LV_RDA;
                    end
                end
                ST_LV_DIV: state_reg <= ST_LV_WAIT;
                ST_LV_WAIT: begin
                    if (div_rsp.done) begin
                        if (!have_r_reg || div_rsp.res < bestr_reg) begin
                            bestr_reg  <= div_rsp.res;
                            lr_reg     <= row_reg;
                            have_r_reg <= 1'b1;
                        end
                        if (row_last) begin
                            state_reg <= ST_LV_DONE;
                        end else begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= ST_LV_RDA;
                        end
                    end
                end
                ST_LV_DONE: begin
                    row_reg <= '0;
                    if (!have_r_reg) begin
                        status_reg <= STAT_UNBOUNDED;
                        state_reg  <= ST_EM_RD;
                    end else if (pcount_reg >= max_piv_reg) begin
                        status_reg <= STAT_LIMIT;
                        state_reg  <= ST_EM_RD;
                    end else begin
                        state_reg <= ST_PR_RDP;
                    end
                end
                // Pivot row divided by the pivot element, written in place.
                ST_PR_RDP: state_reg <= ST_PR_GETP;
                ST_PR_GETP: begin
                    p_reg     <= rdata;
                    col_reg   <= '0;
                    state_reg <= ST_PR_RD;
                end
                ST_PR_RD: begin
                    if (col_idx == ec_reg) begin
                        col_reg <= col_reg + 1'b1;
                        if (col_last) begin
                            row_reg   <= elim_row('0, lr_reg, nr);
                            state_reg <= ST_EL_RDF;
                        end
                    end else begin
                        state_reg <= ST_PR_DIV;
                    end
                end
                ST_PR_DIV: state_reg <= ST_PR_WAIT;
                ST_PR_WAIT: begin
                    if (div_rsp.done) begin
                        col_reg <= col_reg + 1'b1;
                        if (col_last) begin
                            row_reg   <= elim_row('0, lr_reg, nr);
                            state_reg <= ST_EL_RDF;
                        end else begin
                            state_reg <= ST_PR_RD;
                        end
                    end
                end
                // Elimination of the pivot column from every other used row and the delta row.
                ST_EL_RDF: state_reg <= ST_EL_GETF;
                ST_EL_GETF: begin
                    f_reg     <= rdata;
                    col_reg   <= '0;
                    state_reg <= ST_EL_RDX;
                end
                ST_EL_RDX: begin
                    if (col_idx == ec_reg) begin
                        col_reg <= col_reg + 1'b1;
                        if (col_last) begin
                            if (row_reg == ROW_W'(DELTA_ROW)) begin
                                pcount_reg <= pcount_reg + 1'b1;
                                col_reg    <= CNT_W'(1);
                                best_reg   <= '0;
                                have_c_reg <= 1'b0;
                                state_reg  <= ST_EN_RD;
                            end else begin
                                row_reg   <= elim_row(row_reg + 1'b1, lr_reg, nr);
                                state_reg <= ST_EL_RDF;
                            end
                        end
                    end else begin
                        state_reg <= ST_EL_RDQ;
                    end
                end
                ST_EL_RDQ: begin
                    x_reg     <= rdata;
                    state_reg <= ST_EL_MUL;
                end
                ST_EL_MUL: state_reg <= ST_EL_WAIT;
                ST_EL_WAIT: begin
                    if (mul_rsp.done) begin
                        col_reg <= col_reg + 1'b1;
                        if (!col_last) begin
                            state_reg <= ST_EL_RDX;
                        end else if (row_reg == ROW_W'(DELTA_ROW)) begin
                            pcount_reg <= pcount_reg + 1'b1;
                            col_reg    <= CNT_W'(1);
                            best_reg   <= '0;
                            have_c_reg <= 1'b0;
                            state_reg  <= ST_EN_RD;
                        end else begin
                            row_reg   <= elim_row(row_reg + 1'b1, lr_reg, nr);
                            state_reg <= ST_EL_RDF;
                        end
                    end
                end
                // One beat per used row, then the status beat.
                ST_EM_RD: state_reg <= ST_EM_OUT;
                ST_EM_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (row_reg == nr) begin
                            m_tdata_reg <= {1'b0, rdata, {COL_W{1'b0}}, status_reg};
                            m_tlast_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end else begin
                            m_tdata_reg <= {1'b0, rdata, basis_mem[row_reg[LR_W-1:0]],
                                            STAT_OPTIMAL};
                            m_tlast_reg <= 1'b0;
                            row_reg     <= row_reg + 1'b1;
                            state_reg   <= ST_EM_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== hdl/sts_tab_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered
// read data. Holds the tableau; no dependencies.
`default_nettype none

module sts_tab_ram #(
    parameter int DEPTH  = 544,
    parameter int DATA_W = 48,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/sts_div.sv =====
// Iterative Q23.24 divider: restoring division, one quotient bit a cycle,
// with saturation. Depends on sts_pkg.
`default_nettype none

module sts_div
    import sts_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire op_req_t req,
    output op_rsp_t      rsp
);

    localparam int DIVD_W = VAL_W + FRAC_W;
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg, fin_reg, done_reg, neg_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [VAL_W-1:0]  mb_reg, rem_reg, rem_next;
    logic [DIVD_W-1:0] quot_reg;
    val_t              res_reg;
    logic [VAL_W:0]    trial;
    logic              ge;
    logic [VAL_W-1:0]  cap, m;

    always_comb begin
        trial    = {rem_reg, quot_reg[DIVD_W-1]};
        ge       = trial >= {1'b0, mb_reg};
        rem_next = ge ? VAL_W'(trial - {1'b0, mb_reg}) : trial[VAL_W-1:0];
        cap      = neg_reg ? CAP_NEG : CAP_POS;
        m        = ((|quot_reg[DIVD_W-1:VAL_W]) || (quot_reg[VAL_W-1:0] > cap))
                   ? cap : quot_reg[VAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start) begin
                if (req.b == '0) begin
                    res_reg  <= (req.a > 0) ? V_MAX : ((req.a < 0) ? V_MIN : '0);
                    done_reg <= 1'b1;
                end else begin
                    neg_reg  <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
                    mb_reg   <= mag(req.b);
                    quot_reg <= {mag(req.a), {FRAC_W{1'b0}}};
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[DIVD_W-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                res_reg  <= neg_reg ? val_t'(~m + 1'b1) : val_t'(m);
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

// ===== hdl/sts_mul.sv =====
// Q23.24 multiplier built from one shared 24 by 24 multiplier over four
// partial products, with truncation and saturation. Depends on sts_pkg.
`default_nettype none

module sts_mul
    import sts_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire op_req_t req,
    output op_rsp_t      rsp
);

    localparam int HALF_W = VAL_W - FRAC_W;
    localparam int PROD_W = 2 * HALF_W;
    localparam int ACC_W  = VAL_W + 2;

    logic              busy_reg, done_reg, neg_reg, ovf_reg;
    logic [2:0]        step_reg;
    logic [HALF_W-1:0] ah_reg, al_reg, bh_reg, bl_reg, opx, opy;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg, msum, cap;
    logic [VAL_W-1:0]  m;
    val_t              res_reg;
    logic [VAL_W-1:0]  ma, mb;

    always_comb begin
        ma = mag(req.a);
        mb = mag(req.b);
        case (step_reg)
            3'd0:    begin opx = ah_reg; opy = bh_reg; end
            3'd1:    begin opx = ah_reg; opy = bl_reg; end
            3'd2:    begin opx = al_reg; opy = bh_reg; end
            default: begin opx = al_reg; opy = bl_reg; end
        endcase
        msum = acc_reg + ACC_W'(prod_reg[PROD_W-1:FRAC_W]);
        cap  = ACC_W'(neg_reg ? CAP_NEG : CAP_POS);
        m    = (ovf_reg || (msum > cap)) ? cap[VAL_W-1:0] : msum[VAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                neg_reg  <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
                ah_reg   <= ma[VAL_W-1:FRAC_W];
                al_reg   <= HALF_W'(ma[FRAC_W-1:0]);
                bh_reg   <= mb[VAL_W-1:FRAC_W];
                bl_reg   <= HALF_W'(mb[FRAC_W-1:0]);
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                prod_reg <= opx * opy;
                case (step_reg)
                    3'd0: ;
                    3'd1: begin
                        ovf_reg <= |prod_reg[PROD_W-1:VAL_W-1-FRAC_W];
                        acc_reg <= {prod_reg[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
                    end
                    3'd2, 3'd3: acc_reg <= acc_reg + ACC_W'(prod_reg);
                    default: begin
                        res_reg  <= neg_reg ? val_t'(~m + 1'b1) : val_t'(m);
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

// ===== hdl/sts_checker.sv =====
// Port-level checks for the simplex tableau solver, bound to the top level.
// Depends on sts_pkg and simplex_tableau_solver_unit.
`default_nettype none

module sts_checker
    import sts_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic [1:0]            s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tlast,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A solve occupies the block, so no beat is taken in the next cycle.
    a_solve_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_SOLVE |=> !s_tready)
        else $error("input taken straight after a solve");

    // Row beats carry no status; the status beat carries no basis column.
    a_row_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[1:0] == STAT_OPTIMAL)
        else $error("status set on a row beat");

    a_last_basis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[6:2] == '0)
        else $error("basis column set on the status beat");

endmodule

bind simplex_tableau_solver_unit sts_checker u_sts_checker (.*);

`default_nettype wire

// ===== sim/simplex_tableau_solver_unit_test.sv =====
// Self-checking testbench for simplex_tableau_solver_unit: directed table, then random
// problems. Needs the sts_pkg package and the solver RTL. An own fixed-point simplex
// predictor gives the expected result beats, but for typed rows, which carry their own.
`timescale 1ns / 1ps

module simplex_tableau_solver_unit_test;
    import sts_pkg::*;

    localparam int  TARGET_ITEMS = 300;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint ONE = 64'sd1 << 24;
    localparam longint VMAX = (64'sd1 <<< 47) - 1;
    localparam longint VMIN = -(64'sd1 <<< 47);

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    simplex_tableau_solver_unit dut (.*);

    // One result beat as the block should send it.
    typedef struct {
        logic [1:0]       status;
        logic [4:0]       basis_col;
        logic [VAL_W-1:0] amount;
        logic             last;
    } beat_t;

    // One row of the directed stimulus table; typed rows carry their own expected beats.
    typedef struct {
        logic [1:0] kind;
        int         row;
        int         col;
        longint     value;
        bit         typed;
        int         e_basis;
        longint     e_rhs;
        logic [1:0] e_status;
        longint     e_obj;
    } stim_t;

    beat_t  awaited_beats[$];
    stim_t  directed[$];
    int     mismatches;
    longint cycles;
    int     items_sent;
    int     burst_left;

    // Shadow of the block: tableau, basis, artificial flags and registers.
    longint    tab [0:MAX_ROWS][0:MAX_COLS-1];
    int        basis_of [0:MAX_ROWS-1];
    bit        art [0:MAX_COLS-1];
    int        reg_rows, reg_cols, reg_mode, reg_pivots;

    // The clock runs at 4 ns.
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- fixed-point arithmetic

    function automatic longint sat48(input longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Q23.24 product, magnitude truncated, saturated by sign.
    function automatic longint fx_mul(input longint a, input longint b);
        bit neg;
        longint unsigned ma, mb, cap, ah, al, bh, bl, hh, m;
        neg = (a < 0) != (b < 0);
        ma = magn(a);
        mb = magn(b);
        cap = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
        ah = ma >> 24;
        al = ma & 64'hFFFFFF;
        bh = mb >> 24;
        bl = mb & 64'hFFFFFF;
        hh = ah * bh;
        if (hh >= (64'd1 << 23)) begin
            m = cap;
        end else begin
            m = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
            if (m > cap) m = cap;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Q23.24 quotient, magnitude truncated, saturated by sign.
    function automatic longint fx_div(input longint a, input longint b);
        bit neg;
        longint unsigned ma, mb, cap, q0, r, f, m;
        if (b == 0) return (a > 0) ? VMAX : ((a < 0) ? VMIN : 0);
        neg = (a < 0) != (b < 0);
        ma = magn(a);
        mb = magn(b);
        cap = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
        q0 = ma / mb;
        r = ma % mb;
        f = 0;
        if (q0 > (64'd1 << 23)) begin
            m = cap;
        end else begin
            for (int k = 0; k < 24; k++) begin
                r = r << 1;
                f = f << 1;
                if (r >= mb) begin
                    r = r - mb;
                    f = f | 1;
                end
            end
            m = (q0 << 24) | f;
            if (m > cap) m = cap;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // ---------------------------------------------------------------- simplex predictor

    function automatic int rows_in_use();
        return (reg_rows < 1) ? 1 : ((reg_rows > MAX_ROWS) ? MAX_ROWS : reg_rows);
    endfunction

    function automatic int cols_in_use();
        return (reg_cols < 2) ? 2 : ((reg_cols > MAX_COLS) ? MAX_COLS : reg_cols);
    endfunction

    // Pivots the shadow tableau until it stops and returns the final status.
    function automatic logic [1:0] run_simplex(input int nr, input int nc);
        int     pivots, ec, lr;
        longint best, bestr, d, ratio, f;
        bit     have_c, have_r;
        longint q [0:MAX_COLS-1];
        pivots = 0;
        forever begin
            best = 0;
            bestr = 0;
            ec = 0;
            lr = 0;
            have_c = 0;
            have_r = 0;
            for (int j = 1; j < nc; j++) begin
                d = tab[DELTA_ROW][j];
                if (reg_mode[1]) d = sat48(-d);
                if (d > best) begin
                    best = d;
                    ec = j;
                    have_c = 1;
                end
            end
            if (!have_c) begin
                // Optimal unless an artificial column is still basic at a positive level.
                for (int i = 0; i < nr; i++)
                    if (art[basis_of[i]] && tab[i][0] > 0) return STAT_INFEASIBLE;
                return STAT_OPTIMAL;
            end
            for (int i = 0; i < nr; i++) begin
                if (tab[i][ec] > 0) begin
                    ratio = fx_div(tab[i][0], tab[i][ec]);
                    if (!have_r || ratio < bestr) begin
                        bestr = ratio;
                        lr = i;
                        have_r = 1;
                    end
                end
            end
            if (!have_r) return STAT_UNBOUNDED;
            if (pivots >= reg_pivots) return STAT_LIMIT;
            for (int j = 0; j < nc; j++) q[j] = fx_div(tab[lr][j], tab[lr][ec]);
            for (int i = 0; i <= MAX_ROWS; i++) begin
                if (i == lr || (i >= nr && i != DELTA_ROW)) continue;
                f = tab[i][ec];
                for (int j = 0; j < nc; j++)
                    tab[i][j] = sat48(tab[i][j] - fx_mul(q[j], f));
                tab[i][ec] = 0;
            end
            for (int j = 0; j < nc; j++) tab[lr][j] = q[j];
            tab[lr][ec] = ONE;
            basis_of[lr] = ec;
            pivots++;
        end
    endfunction

    // Applies one accepted input beat to the shadow and queues the beats it causes.
    task automatic predict_beat(input stim_t s);
        int         nr, nc;
        logic [1:0] st;
        beat_t      b;
        longint     v;
        nr = rows_in_use();
        nc = cols_in_use();
        v = s.value;
        case (s.kind)
            KIND_TAB: begin
                if (s.row == DELTA_ROW || s.row == nr) tab[DELTA_ROW][s.col] = v;
                else if (s.row < MAX_ROWS) tab[s.row][s.col] = v;
            end
            KIND_BASIS: begin
                if (s.row < MAX_ROWS) basis_of[s.row] = s.col;
            end
            KIND_ART: art[s.col] = v[0];
            default: begin
                st = run_simplex(nr, nc);
                for (int i = 0; i < nr; i++) begin
                    b.status = STAT_OPTIMAL;
                    b.basis_col = s.typed ? 5'(s.e_basis) : 5'(basis_of[i]);
                    b.amount = s.typed ? s.e_rhs[VAL_W-1:0] : tab[i][0][VAL_W-1:0];
                    b.last = 1'b0;
                    awaited_beats.push_back(b);
                end
                b.status = s.typed ? s.e_status : st;
                b.basis_col = '0;
                b.amount = s.typed ? s.e_obj[VAL_W-1:0] : tab[DELTA_ROW][0][VAL_W-1:0];
                b.last = 1'b1;
                awaited_beats.push_back(b);
            end
        endcase
    endtask

    // ---------------------------------------------------------------- drivers

    // Sends one beat; bursts of random length are broken by random gaps.
    task automatic send_beat(input stim_t s);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.kind;
        s_tdata  <= {6'b0, s.value[VAL_W-1:0], 5'(s.col), 5'(s.row)};
        // Handshake levels are stable by the falling edge, so the beat goes at the next rise.
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        predict_beat(s);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_item(input logic [1:0] kind, input int row, input int col,
                             input longint value);
        stim_t s;
        s = '{kind, row, col, value, 1'b0, 0, 0, 2'b0, 0};
        send_beat(s);
    endtask

    // Waits until every awaited beat has arrived and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        case (idx)
            REG_NUM_ROWS:   reg_rows = data & 32'h1F;
            REG_NUM_COLS:   reg_cols = data & 32'h3F;
            REG_MODE:       reg_mode = data & 32'h3;
            REG_MAX_PIVOTS: reg_pivots = data & 32'hFFF;
            default: ;
        endcase
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stretches of always-ready, random stalls and a slow toggle.
    int stall_mode, stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(5, 60);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 2) != 0);
                default: m_tready <= cycles[2];
            endcase
        end
    end

    // Result checker, sampled at the falling edge ahead of the accepting rise.
    always @(negedge aclk) begin
        beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h last %b", m_tdata, m_tlast);
            end else begin
                e = awaited_beats.pop_front();
                if (m_tdata[1:0] !== e.status || m_tdata[6:2] !== e.basis_col ||
                    m_tdata[54:7] !== e.amount || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected st %0d col %0d amt %h last %b,",
                                  " got st %0d col %0d amt %h last %b"},
                                 e.status, e.basis_col, e.amount, e.last,
                                 m_tdata[1:0], m_tdata[6:2], m_tdata[54:7], m_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------- random problems

    function automatic longint rand_entry(input bit rhs);
        int pick;
        pick = $urandom_range(0, 31);
        if (pick == 0) return VMAX;
        if (pick == 1) return VMIN;
        if (pick == 2) return 0;
        if (pick == 3) return 1;
        if (pick == 4) return longint'({$urandom, $urandom}) >>> 16;
        if (rhs) return longint'($urandom_range(0, 16 << 8)) << 16;
        return (longint'($urandom_range(0, 12 << 8)) - (4 << 8)) << 16;
    endfunction

    // Loads a whole problem at the current size, mixed with ignored beats, then solves.
    task automatic load_and_solve();
        int nr, nc;
        nr = rows_in_use();
        nc = cols_in_use();
        for (int r = 0; r <= nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                if (r == nr)
                    send_item(KIND_TAB, ($urandom_range(0, 1) != 0) ? DELTA_ROW : nr, c,
                              rand_entry(0));
                else
                    send_item(KIND_TAB, r, c, rand_entry(c == 0));
                if ($urandom_range(0, 15) == 0)
                    send_item(KIND_TAB, $urandom_range(17, 31), $urandom_range(0, 31),
                              rand_entry(0));
            end
            if (r < nr)
                send_item(KIND_BASIS, r, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 31) : $urandom_range(0, nc - 1), 0);
        end
        for (int c = 0; c < nc; c++)
            if ($urandom_range(0, 2) == 0)
                send_item(KIND_ART, $urandom_range(0, 31), c, longint'({$urandom, $urandom}));
        if ($urandom_range(0, 3) == 0)
            send_item(KIND_BASIS, $urandom_range(16, 31), $urandom_range(0, 31), 0);
        if ($urandom_range(0, 3) == 0 && nr < MAX_ROWS - 1)
            send_item(KIND_TAB, $urandom_range(nr + 1, MAX_ROWS - 1), $urandom_range(0, 31),
                      rand_entry(0));
        send_item(KIND_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
                  longint'({$urandom, $urandom}));
        if ($urandom_range(0, 4) == 0) send_item(KIND_SOLVE, 0, 0, 0);
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        stim_t s;
        int    mode_codes [4];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mismatches = 0;
        cycles = 0;
        items_sent = 0;
        burst_left = 0;
        reg_rows = 1;
        reg_cols = 32;
        reg_mode = 1;
        reg_pivots = 255;
        foreach (art[i]) art[i] = 1'b0;
        mode_codes = '{1, 3, 2, 0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: one row, two columns, so every typed answer is worked by hand.
        write_reg(REG_NUM_ROWS, 1);
        write_reg(REG_NUM_COLS, 2);
        write_reg(REG_MODE, 1);
        write_reg(REG_MAX_PIVOTS, 4095);
        write_reg(4'd7, 12'hFFF);

        directed = '{
            '{KIND_TAB, 0, 0, 4 * ONE, 0, 0, 0, 0, 0},
            '{KIND_TAB, 0, 1, 2 * ONE, 0, 0, 0, 0, 0},
            '{KIND_TAB, DELTA_ROW, 0, 0, 0, 0, 0, 0, 0},
            '{KIND_TAB, 1, 1, 3 * ONE, 0, 0, 0, 0, 0},
            '{KIND_BASIS, 0, 0, 0, 0, 0, 0, 0, 0},
            // One pivot on column one, then optimal.
            '{KIND_SOLVE, 0, 0, 0, 1, 1, 2 * ONE, STAT_OPTIMAL, -6 * ONE},
            // Flag the basic column as artificial: now infeasible.
            '{KIND_ART, 0, 1, -1, 0, 0, 0, 0, 0},
            '{KIND_SOLVE, 31, 31, VMIN, 1, 1, 2 * ONE, STAT_INFEASIBLE, -6 * ONE},
            // Entering column with no positive entry: unbounded.
            '{KIND_TAB, 0, 1, -ONE, 0, 0, 0, 0, 0},
            '{KIND_TAB, DELTA_ROW, 1, ONE, 0, 0, 0, 0, 0},
            '{KIND_SOLVE, 0, 0, 0, 1, 1, 2 * ONE, STAT_UNBOUNDED, -6 * ONE},
            // Ignored writes: row past the delta code, basis row out of range.
            '{KIND_TAB, 17, 31, VMIN, 0, 0, 0, 0, 0},
            '{KIND_TAB, 31, 0, VMAX, 0, 0, 0, 0, 0},
            '{KIND_BASIS, 31, 31, 0, 0, 0, 0, 0, 0},
            '{KIND_BASIS, 16, 0, 0, 0, 0, 0, 0, 0},
            '{KIND_ART, 31, 31, 2, 0, 0, 0, 0, 0},
            // Extreme values: a one-LSB pivot under a full-scale right-hand side.
            '{KIND_TAB, 0, 0, VMAX, 0, 0, 0, 0, 0},
            '{KIND_TAB, 0, 1, 1, 0, 0, 0, 0, 0},
            '{KIND_TAB, DELTA_ROW, 0, VMIN, 0, 0, 0, 0, 0},
            '{KIND_TAB, 1, 1, VMAX, 0, 0, 0, 0, 0},
            '{KIND_SOLVE, 0, 0, 0, 0, 0, 0, 0, 0},
            '{KIND_TAB, DELTA_ROW, 1, VMIN, 0, 0, 0, 0, 0},
            '{KIND_ART, 0, 1, 0, 0, 0, 0, 0, 0},
            '{KIND_SOLVE, 0, 0, 0, 0, 0, 0, 0, 0}
        };
        foreach (directed[i]) begin
            s = directed[i];
            send_beat(s);
        end

        // Random part: a fresh setting per problem, then two with clamped sizes.
        while (items_sent < TARGET_ITEMS - 150) begin
            wait_idle();
            write_reg(REG_NUM_ROWS, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
            write_reg(REG_NUM_COLS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                              : $urandom_range(2, 6));
            write_reg(REG_MODE, mode_codes[$urandom_range(0, 3)]);
            write_reg(REG_MAX_PIVOTS, ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10));
            load_and_solve();
        end
        // More rows than the tableau holds, with few columns.
        wait_idle();
        write_reg(REG_NUM_ROWS, 20);
        write_reg(REG_NUM_COLS, 3);
        write_reg(REG_MODE, 3);
        write_reg(REG_MAX_PIVOTS, 2);
        load_and_solve();
        // More columns than the tableau holds, with one row.
        wait_idle();
        write_reg(REG_NUM_ROWS, 1);
        write_reg(REG_NUM_COLS, 40);
        load_and_solve();

        wait_idle();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && awaited_beats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sts_pkg.sv
hdl/sts_tab_ram.sv
hdl/sts_div.sv
hdl/sts_mul.sv
hdl/simplex_tableau_solver_unit.sv
hdl/sts_checker.sv
sim/simplex_tableau_solver_unit_test.sv
